@@ rtl/rfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared constants, types and helper functions of the ring FIFO with search.
// ----------------------------------------------------------------------------
package rfs_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 11;
    localparam int FIDX_W = 11;
    localparam int COUNT_W = 11;

    localparam logic [OP_W-1:0] OP_ENQ    = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new request
        logic rd_head;    // read the head entry, start a walk
        logic srch_next;  // read the next entry of the walk
        logic srch_hit;   // record the current walk offset as the hit
        logic commit;     // update queue state and load the result register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            hit;
        logic            last;
    } t_sts;

    // Saturate the capacity register to the range 1..DEPTH
    function automatic logic [CNT_W-1:0] cap_sat(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap == '0) begin
            res = CNT_W'(1);
        end else if ({21'd0, cap} > 32'(DEPTH)) begin
            res = CNT_W'(DEPTH);
        end else begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

    // Advance a pointer, wrapping at the capacity in use
    function automatic logic [ADDR_W-1:0] ptr_adv(input logic [ADDR_W-1:0] p,
                                                  input logic [CNT_W-1:0]  cap);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + CNT_W'(1);
        return (n >= cap) ? '0 : n[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/rfs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_ctrl
// Request sequencer: accepts a request, drives the memory read or search
// walk, and hands the result to the output register.
// ----------------------------------------------------------------------------
module rfs_ctrl
    import rfs_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_OP;
                end
            end
            S_OP: begin
                if (i_sts.op == OP_SEARCH && !i_sts.empty) begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_SRCH;
                end else if ((i_sts.op inside {OP_DEQ, OP_PEEK}) && !i_sts.empty) begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RD: begin
                n_state = S_FIN;
            end
            S_SRCH: begin
                if (i_sts.hit) begin
                    o_cmd.srch_hit = 1'b1;
                    n_state        = S_FIN;
                end else if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.srch_next = 1'b1;
                end
            end
            S_FIN: begin
                // hold until the result register is free
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_OP))
        else $error("accepted request did not enter decode");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    a_read_then_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_FIN))
        else $error("read wait did not finish");

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("commit did not present a result");
`endif

endmodule
`default_nettype wire

@@ rtl/rfs_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_dpath
// Queue store, pointers, fill count, search walker and result register.
// ----------------------------------------------------------------------------
module rfs_dpath
    import rfs_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_valid,
    input  wire        [CAP_W-1:0]    i_cfg_data,
    input  wire        [OP_W-1:0]     i_op,
    input  wire signed [DATA_W-1:0]   i_value,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    output logic                      o_status,
    output logic signed [DATA_W-1:0]  o_data,
    output logic signed [FIDX_W-1:0]  o_found_index,
    output logic        [COUNT_W-1:0] o_count,
    output logic                      o_empty_res,
    output logic                      o_full_res
);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0]  r_cap;
    logic [ADDR_W-1:0] r_head, r_tail, r_sptr;
    logic [CNT_W-1:0]  r_fill, r_sidx;
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_value, r_rd_data;
    logic [FIDX_W-1:0] r_found;

    logic [CNT_W-1:0]  cap;
    logic [ADDR_W-1:0] n_head, n_tail, rd_addr;
    logic [CNT_W-1:0]  n_fill;
    logic              res_status, empty, full, do_wr, rd_en;
    logic [DATA_W-1:0] res_data;

    assign cap   = cap_sat(r_cap);
    assign empty = (r_fill == '0);
    assign full  = (r_fill >= cap);

    assign o_sts.op    = r_op;
    assign o_sts.empty = empty;
    assign o_sts.hit   = (r_rd_data == r_value);
    assign o_sts.last  = ((r_sidx + CNT_W'(1)) == r_fill);

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        res_status = 1'b0;
        res_data   = '0;
        do_wr      = 1'b0;
        case (r_op)
            OP_ENQ: begin
                if (full) begin
                    res_status = 1'b1;
                end else begin
                    do_wr  = 1'b1;
                    n_tail = ptr_adv(r_tail, cap);
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            OP_DEQ: begin
                if (empty) begin
                    res_status = 1'b1;
                end else begin
                    res_data = r_rd_data;
                    n_head   = ptr_adv(r_head, cap);
                    n_fill   = r_fill - CNT_W'(1);
                end
            end
            OP_PEEK: begin
                if (empty) begin
                    res_status = 1'b1;
                end else begin
                    res_data = r_rd_data;
                end
            end
            OP_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_fill = '0;
            end
            OP_SEARCH: begin
                res_status = 1'b0;
            end
            default: begin
                res_status = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_fill <= n_fill;
            end
        end
    end

    // Request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_found <= '1;
        end
        if (i_cmd.rd_head) begin
            r_sptr <= ptr_adv(r_head, cap);
            r_sidx <= '0;
        end else if (i_cmd.srch_next) begin
            r_sptr <= ptr_adv(r_sptr, cap);
            r_sidx <= r_sidx + CNT_W'(1);
        end
        if (i_cmd.srch_hit) begin
            r_found <= FIDX_W'(r_sidx);
        end
    end

    // Store: one write port, one registered read port
    assign rd_addr = i_cmd.rd_head ? r_head : r_sptr;
    assign rd_en   = i_cmd.rd_head || i_cmd.srch_next;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_wr) begin
            mem[r_tail] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_status      <= res_status;
            o_data        <= res_data;
            o_found_index <= r_found;
            o_count       <= COUNT_W'(n_fill);
            o_empty_res   <= (n_fill == '0);
            o_full_res    <= (n_fill >= cap);
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count exceeds store depth");

    a_enq_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && do_wr) |=> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("enqueue did not advance fill");
`endif

endmodule
`default_nettype wire

@@ rtl/ring_fifo_with_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_fifo_with_search
// Circular FIFO of signed 32-bit words with enqueue, dequeue, peek, clear and
// linear search, each request giving one result.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Enqueue, clear, rejected requests and
// unknown ops go from decode straight to the finish state; dequeue and peek
// first pass a read wait state for the registered read of the store. Search
// walks the queue from the head and compares k entries (the hit offset
// plus one, or the fill count on a miss), one store read per entry. A new
// request is accepted as soon as the previous one has been placed in the
// result register, even while that result still waits to be taken. The
// capacity register is written through its own port and must only change
// while the block is idle; values of 0 act as 1 and values above 1024 as 1024.
// ----------------------------------------------------------------------------
module ring_fifo_with_search
    import rfs_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire        [CAP_W-1:0]    i_cfg_data,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire        [OP_W-1:0]     i_op,
    input  wire signed [DATA_W-1:0]   i_value,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output logic                      o_status,
    output logic signed [DATA_W-1:0]  o_data,
    output logic signed [FIDX_W-1:0]  o_found_index,
    output logic        [COUNT_W-1:0] o_count,
    output logic                      o_empty_res,
    output logic                      o_full_res
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    rfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rfs_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_data        (o_data),
        .o_found_index (o_found_index),
        .o_count       (o_count),
        .o_empty_res   (o_empty_res),
        .o_full_res    (o_full_res)
    );

endmodule
`default_nettype wire
